// ===== sv/srs_pkg.sv =====
`timescale 1ns / 1ps

package srs_pkg;

    localparam int SRS_ADDR_W = 5;
    localparam int SRS_DATA_W = 64;
    localparam int SRS_LEN_W  = 4;
    localparam int SRS_CNT_W  = 4;

    localparam logic [1:0] SRS_REG_PLEN  = 2'd0;
    localparam logic [1:0] SRS_REG_PBYTE = 2'd1;
    localparam logic [1:0] SRS_REG_RLEN  = 2'd2;
    localparam logic [1:0] SRS_REG_RBYTE = 2'd3;

    typedef struct packed {
        logic [SRS_LEN_W-1:0]  pattern_length;
        logic [SRS_DATA_W-1:0] pattern_bytes;
        logic [SRS_LEN_W-1:0]  replacement_length;
        logic [SRS_DATA_W-1:0] replacement_bytes;
    } srs_cfg_t;

    typedef struct packed {
        logic [SRS_CNT_W-1:0] count;
        logic                 last;
    } srs_cmd_ctl_t;

endpackage

// ===== sv/srs_in_if.sv =====
`timescale 1ns / 1ps

interface srs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/srs_out_if.sv =====
`timescale 1ns / 1ps

interface srs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;

    modport source (output valid, output out_byte, output out_valid, output out_end,
                    input ready);
    modport sink (input valid, input out_byte, input out_valid, input out_end,
                  output ready);
endinterface

// ===== sv/substring_replace_stream.sv =====
`timescale 1ns / 1ps

// Streaming find-and-replace. Source bytes arrive on the text channel, one per
// transfer, with in_last on the final byte of a string. Rewritten bytes leave
// on the rewritten channel; out_valid low marks a bare end marker and out_end
// marks the final result of a string. Both channels transfer on valid and ready.
// The APB port sets the pattern and the replacement; write it only while idle.
// Writing the pattern length discards any bytes held in the match window.
// A byte's first result passes the queue, the command register and the output
// register. One source byte is taken every cycle as long as each byte releases
// at most one result; a byte that releases a replacement or a flush of the
// window holds the output register for each result byte in turn, and the
// two-entry command queue between the front and back ends absorbs the rest.
// A stalled receiver holds the current result and, once the queue fills,
// drops ready on the text channel. Reset clears the registers, the window
// count, the queue and the output register; no clearing pass is needed.
module substring_replace_stream
    import srs_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    srs_in_if.sink                text,
    srs_out_if.source             rewritten,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [SRS_ADDR_W-1:0] paddr,
    input  logic [SRS_DATA_W-1:0] pwdata,
    output logic [SRS_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CMD_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT + 1) ?
                               MAX_PATTERN : MAX_REPLACEMENT + 1;
    localparam int CTL_W     = $bits(srs_cmd_ctl_t);
    localparam int CMD_W     = CTL_W + CMD_DEPTH * 8;

    srs_cfg_t                  cfg;
    logic                      win_clear;
    logic                      q_full;
    logic                      push;
    srs_cmd_ctl_t              push_ctl;
    logic [CMD_DEPTH-1:0][7:0] push_data;
    logic                      q_valid;
    logic                      q_pop;
    logic [CMD_W-1:0]          q_word;
    srs_cmd_ctl_t              q_ctl;
    logic [CMD_DEPTH-1:0][7:0] q_data;

    assign q_ctl  = q_word[CMD_W-1 -: CTL_W];
    assign q_data = q_word[CMD_DEPTH*8-1:0];

    srs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .win_clear (win_clear)
    );

    srs_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .CMD_DEPTH       (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg       (cfg),
        .win_clear (win_clear),
        .q_full    (q_full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_data (push_data)
    );

    srs_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_data}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_word)
    );

    srs_back #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctl     (q_ctl),
        .q_data    (q_data),
        .rewritten (rewritten)
    );

endmodule

// ===== sv/srs_cfg.sv =====
`timescale 1ns / 1ps

module srs_cfg
    import srs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [SRS_ADDR_W-1:0] paddr,
    input  logic [SRS_DATA_W-1:0] pwdata,
    output logic [SRS_DATA_W-1:0] prdata,
    output logic                  pready,
    output srs_cfg_t              cfg,
    output logic                  win_clear
);

    srs_cfg_t   cfg_reg;
    srs_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[SRS_ADDR_W-1:SRS_ADDR_W-2];
    assign win_clear = wr_en && (reg_index == SRS_REG_PLEN);
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                SRS_REG_PLEN:  cfg_next.pattern_length     = pwdata[SRS_LEN_W-1:0];
                SRS_REG_PBYTE: cfg_next.pattern_bytes      = pwdata;
                SRS_REG_RLEN:  cfg_next.replacement_length = pwdata[SRS_LEN_W-1:0];
                SRS_REG_RBYTE: cfg_next.replacement_bytes  = pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            SRS_REG_PLEN:
                prdata = {{(SRS_DATA_W-SRS_LEN_W){1'b0}}, cfg_reg.pattern_length};
            SRS_REG_PBYTE:
                prdata = cfg_reg.pattern_bytes;
            SRS_REG_RLEN:
                prdata = {{(SRS_DATA_W-SRS_LEN_W){1'b0}}, cfg_reg.replacement_length};
            SRS_REG_RBYTE:
                prdata = cfg_reg.replacement_bytes;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/srs_front.sv =====
`timescale 1ns / 1ps

module srs_front
    import srs_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int CMD_DEPTH       = 9
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    srs_in_if.sink                    text,
    input  srs_cfg_t                  cfg,
    input  logic                      win_clear,
    input  logic                      q_full,
    output logic                      push,
    output srs_cmd_ctl_t              push_ctl,
    output logic [CMD_DEPTH-1:0][7:0] push_data
);

    localparam int WC_W = $clog2(MAX_PATTERN + 1);
    localparam int RC_W = $clog2(MAX_REPLACEMENT + 1);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [WC_W-1:0]             wcnt_reg;
    logic [WC_W-1:0]             wcnt_next;

    logic [WC_W-1:0]             plen_eff;
    logic [RC_W-1:0]             rlen_eff;
    logic [WC_W-1:0]             cnt_eff;
    logic [WC_W-1:0]             cnt_new;
    logic [MAX_PATTERN-1:0][7:0] wnew;
    logic                        full;
    logic                        same;
    logic                        accept;

    assign text.ready = !q_full;
    assign accept     = text.valid && !q_full;

    always_comb
    begin
        if (cfg.pattern_length > SRS_LEN_W'(MAX_PATTERN))
            plen_eff = WC_W'(MAX_PATTERN);
        else
            plen_eff = WC_W'(cfg.pattern_length);
        if (cfg.replacement_length > SRS_LEN_W'(MAX_REPLACEMENT))
            rlen_eff = RC_W'(MAX_REPLACEMENT);
        else
            rlen_eff = RC_W'(cfg.replacement_length);

        cnt_eff = (wcnt_reg >= plen_eff) ? '0 : wcnt_reg;
        cnt_new = cnt_eff + 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            wnew[i] = (cnt_eff == WC_W'(i)) ? text.in_byte : win_reg[i];
        end
        full = (plen_eff != '0) && (cnt_new == plen_eff);

        same = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((WC_W'(i) < plen_eff) && (wnew[i] != cfg.pattern_bytes[8*i +: 8]))
                same = 1'b0;
        end
    end

    // Build the list of bytes this transfer releases.
    always_comb
    begin
        push_data     = '0;
        push_ctl.last = text.in_last;
        if (plen_eff == '0)
        begin
            push_data[0] = text.in_byte;
            for (int i = 0; i < MAX_REPLACEMENT; i++)
            begin
                push_data[i+1] = cfg.replacement_bytes[8*i +: 8];
            end
            push_ctl.count = SRS_CNT_W'(rlen_eff) + 1'b1;
        end
        else if (full && same)
        begin
            for (int i = 0; i < MAX_REPLACEMENT; i++)
            begin
                push_data[i] = cfg.replacement_bytes[8*i +: 8];
            end
            push_ctl.count = SRS_CNT_W'(rlen_eff);
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                push_data[i] = wnew[i];
            end
            if (text.in_last)
                push_ctl.count = SRS_CNT_W'(cnt_new);
            else if (full)
                push_ctl.count = SRS_CNT_W'(1);
            else
                push_ctl.count = '0;
        end
        push = accept && ((push_ctl.count != '0) || text.in_last);
    end

    always_comb
    begin
        win_next  = win_reg;
        wcnt_next = wcnt_reg;
        if (win_clear)
        begin
            wcnt_next = '0;
        end
        else if (accept && (plen_eff != '0))
        begin
            if ((full && same) || text.in_last)
            begin
                wcnt_next = '0;
            end
            else if (full)
            begin
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    win_next[i] = wnew[i+1];
                end
                win_next[MAX_PATTERN-1] = wnew[MAX_PATTERN-1];
                wcnt_next = cnt_new - 1'b1;
            end
            else
            begin
                win_next  = wnew;
                wcnt_next = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
        end
        else
        begin
            wcnt_reg <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// ===== sv/srs_queue.sv =====
`timescale 1ns / 1ps

module srs_queue #(
    parameter int WIDTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/srs_back.sv =====
`timescale 1ns / 1ps

module srs_back
    import srs_pkg::*;
#(
    parameter int CMD_DEPTH = 9
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  srs_cmd_ctl_t              q_ctl,
    input  logic [CMD_DEPTH-1:0][7:0] q_data,
    srs_out_if.source                 rewritten
);

    localparam int IDX_W = $clog2(CMD_DEPTH);

    logic                      busy_reg;
    srs_cmd_ctl_t              ctl_reg;
    logic [CMD_DEPTH-1:0][7:0] data_reg;
    logic [SRS_CNT_W-1:0]      idx_reg;
    logic                      ovalid_reg;
    logic [7:0]                obyte_reg;
    logic                      obvalid_reg;
    logic                      oend_reg;

    logic                      advance;
    logic                      final_res;
    logic                      load;
    logic                      has_byte;

    assign has_byte  = (ctl_reg.count != '0);
    assign advance   = busy_reg && (!ovalid_reg || rewritten.ready);
    assign final_res = !has_byte || (idx_reg + 1'b1 == ctl_reg.count);
    assign load      = q_valid && (!busy_reg || (advance && final_res));
    assign q_pop     = load;

    assign rewritten.valid     = ovalid_reg;
    assign rewritten.out_byte  = obyte_reg;
    assign rewritten.out_valid = obvalid_reg;
    assign rewritten.out_end   = oend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                if (final_res)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end

            if (advance)
                ovalid_reg <= 1'b1;
            else if (rewritten.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg  <= q_ctl;
            data_reg <= q_data;
        end
        if (advance)
        begin
            obyte_reg   <= has_byte ? data_reg[idx_reg[IDX_W-1:0]] : 8'd0;
            obvalid_reg <= has_byte;
            oend_reg    <= ctl_reg.last && final_res;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import srs_pkg::*;

    class find_replace_model;
        typedef struct {
            logic [7:0] data;
            logic       carries;
            logic       ends;
        } rewritten_t;

        logic [3:0]  pat_len;
        logic [63:0] pat;
        logic [3:0]  rep_len;
        logic [63:0] rep;
        logic [7:0]  window [8];
        int unsigned held;
        rewritten_t  expected_q [$];
        int          errors;
        int          bytes_taken;
        int          results_seen;

        function new();
            pat_len = '0;
            pat = '0;
            rep_len = '0;
            rep = '0;
            held = 0;
            errors = 0;
            bytes_taken = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                SRS_REG_PLEN:
                begin
                    pat_len = value[3:0];
                    held = 0;
                end
                SRS_REG_PBYTE: pat = value;
                SRS_REG_RLEN:  rep_len = value[3:0];
                SRS_REG_RBYTE: rep = value;
                default: ;
            endcase
        endfunction

        function logic [63:0] reg_value(logic [1:0] idx);
            case (idx)
                SRS_REG_PLEN:  return {60'd0, pat_len};
                SRS_REG_PBYTE: return pat;
                SRS_REG_RLEN:  return {60'd0, rep_len};
                default:       return rep;
            endcase
        endfunction

        function void add(logic [7:0] data, logic carries);
            rewritten_t r;
            r.data = data;
            r.carries = carries;
            r.ends = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void take_source_byte(logic [7:0] b, logic last);
            int unsigned plen;
            int unsigned rlen;
            int unsigned first;
            int unsigned i;
            bit same;
            first = expected_q.size();
            bytes_taken++;
            plen = (pat_len > 8) ? 8 : pat_len;
            rlen = (rep_len > 8) ? 8 : rep_len;
            if (plen == 0)
            begin
                add(b, 1'b1);
                for (i = 0; i < rlen; i++)
                    add(rep[8*i +: 8], 1'b1);
            end
            else
            begin
                if (held >= plen)
                    held = 0;
                window[held] = b;
                held++;
                if (held == plen)
                begin
                    same = 1;
                    for (i = 0; i < plen; i++)
                        if (window[i] != pat[8*i +: 8])
                            same = 0;
                    if (same)
                    begin
                        for (i = 0; i < rlen; i++)
                            add(rep[8*i +: 8], 1'b1);
                        held = 0;
                    end
                    else
                    begin
                        add(window[0], 1'b1);
                        for (i = 0; i < 7; i++)
                            window[i] = window[i+1];
                        held--;
                    end
                end
                if (last)
                begin
                    for (i = 0; i < held; i++)
                        add(window[i], 1'b1);
                    held = 0;
                end
            end
            if (last)
            begin
                if (expected_q.size() == first)
                    add(8'h00, 1'b0);
                expected_q[expected_q.size()-1].ends = 1'b1;
            end
        endfunction

        task report(string what);
            $display("%0t MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_rewritten(logic [7:0] data, logic carries, logic ends);
            rewritten_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result byte=%02h valid=%b end=%b",
                                 data, carries, ends));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (data !== want.data)
                report($sformatf("out_byte %02h, expected %02h", data, want.data));
            if (carries !== want.carries)
                report($sformatf("out_valid %b, expected %b", carries, want.carries));
            if (ends !== want.ends)
                report($sformatf("out_end %b, expected %b", ends, want.ends));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [SRS_ADDR_W-1:0] paddr;
    logic [SRS_DATA_W-1:0] pwdata;
    logic [SRS_DATA_W-1:0] prdata;
    logic                  pready;

    srs_in_if  text_ch ();
    srs_out_if rw_ch ();

    find_replace_model rewriter;
    bit sender_idles;
    bit receiver_idles;
    int hold_req;
    int settings_used;

    substring_replace_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .rewritten (rw_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver holds off for a long stretch whenever a new request is posted.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rw_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                rw_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!receiver_idles)
                rw_ch.ready <= 1'b1;
            else
                rw_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rw_ch.valid && rw_ch.ready)
            rewriter.check_rewritten(rw_ch.out_byte, rw_ch.out_valid, rw_ch.out_end);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (sender_idles && $urandom_range(99) < 26)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        text_ch.in_last <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        rewriter.take_source_byte(b, last);
    endtask

    task automatic send_str(input string s, input logic last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (rewriter.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rewriter.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check_reg(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== rewriter.reg_value(idx))
            rewriter.report($sformatf("register %0d reads %016h, expected %016h",
                                      idx, prdata, rewriter.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [3:0] plen, input logic [63:0] pbytes,
                             input logic [3:0] rlen, input logic [63:0] rbytes);
        wait_drained();
        apb_write(SRS_REG_PLEN, {60'd0, plen});
        apb_write(SRS_REG_PBYTE, pbytes);
        apb_write(SRS_REG_RLEN, {60'd0, rlen});
        apb_write(SRS_REG_RBYTE, rbytes);
        apb_check_reg(SRS_REG_PLEN);
        apb_check_reg(SRS_REG_PBYTE);
        apb_check_reg(SRS_REG_RLEN);
        apb_check_reg(SRS_REG_RBYTE);
        settings_used++;
    endtask

    // Strings are mostly built from whole and partial copies of the pattern so
    // that matches, near misses and flushes all happen often.
    task automatic random_stream(input int n, input bit close);
        logic [7:0] chunk [$];
        int sent;
        int len;
        int eff;
        int k;
        int i;
        sent = 0;
        eff = (rewriter.pat_len > 8) ? 8 : rewriter.pat_len;
        while (sent < n)
        begin
            len = $urandom_range(1, 12);
            if (len > n - sent)
                len = n - sent;
            chunk.delete();
            while (chunk.size() < len)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        if (eff == 0)
                            chunk.push_back(8'($urandom));
                        for (i = 0; i < eff; i++)
                            chunk.push_back(rewriter.pat[8*i +: 8]);
                    end
                    4, 5:
                    begin
                        k = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
                        for (i = 0; i < k; i++)
                            chunk.push_back(rewriter.pat[8*i +: 8]);
                    end
                    6, 7:
                    begin
                        k = $urandom_range(0, 7);
                        chunk.push_back(rewriter.pat[8*k +: 8]);
                    end
                    default: chunk.push_back(8'($urandom));
                endcase
            end
            while (chunk.size() > len)
                void'(chunk.pop_back());
            for (i = 0; i < len; i++)
                send_byte(chunk[i], (i == len - 1) && (close || sent + len < n));
            sent += len;
        end
    endtask

    initial
    begin
        int ph;
        int i;
        logic [3:0]  plen;
        logic [63:0] pbytes;

        rewriter = new();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_req = 0;
        settings_used = 0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        text_ch.valid   <= 1'b0;
        text_ch.in_byte <= 8'h00;
        text_ch.in_last <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(4'd3, 64'h636261, 4'd2, 64'h5958);
        send_str("abc", 1'b1);
        send_str("zabcab", 1'b1);
        configure(4'd3, 64'h636261, 4'd0, 64'h5958);
        send_str("abc", 1'b1);
        // These bytes stay in the window and are dropped by the next length write.
        send_str("za", 1'b0);
        configure(4'd0, 64'd0, 4'd0, 64'd0);
        send_byte(8'hFF, 1'b1);
        configure(4'd0, 64'd0, 4'd8, '1);
        send_byte(8'h00, 1'b1);
        configure(4'd15, 64'h00FF_18E7_A55A_3CC3, 4'd15, 64'h0123_4567_89AB_CDEF);
        for (i = 0; i < 8; i++)
            send_byte(rewriter.pat[8*i +: 8], i == 7);

        for (ph = 0; ph < 7; ph++)
        begin
            sender_idles = (ph != 2);
            receiver_idles = (ph != 2);
            if (ph == 4)
                configure(4'd0, {$urandom, $urandom}, 4'($urandom_range(1, 8)),
                          {$urandom, $urandom});
            else
            begin
                case ($urandom_range(0, 9))
                    0:       plen = 4'd0;
                    9:       plen = 4'($urandom_range(9, 15));
                    default: plen = 4'($urandom_range(1, 8));
                endcase
                pbytes = {$urandom, $urandom};
                if ($urandom_range(0, 2) == 0)
                    pbytes = {8{pbytes[7:0]}};
                configure(plen, pbytes, 4'($urandom_range(0, 15)), {$urandom, $urandom});
            end
            if (ph == 4)
                hold_req <= hold_req + 1;
            if (ph == 5)
            begin
                random_stream(10, 1'b1);
                wait_drained();
                random_stream(11, 1'b1);
            end
            else
                random_stream(21, ph != 3);
        end
        wait_drained();

        $display("Streamed %0d source bytes and checked %0d rewritten results",
                 rewriter.bytes_taken, rewriter.results_seen);
        $display("under %0d register settings, with back-pressure and idle gaps.",
                 settings_used);
        if (rewriter.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/srs_pkg.sv
sv/srs_in_if.sv
sv/srs_out_if.sv
sv/srs_cfg.sv
sv/srs_front.sv
sv/srs_queue.sv
sv/srs_back.sv
sv/substring_replace_stream.sv
dv/tb_top.sv
